@@ rtl/ohte_pkg.sv @@
// Shared types, constants and helpers of the ordered hash table engine.
package ohte_pkg;

    localparam int ENTRIES = 255;
    localparam int NSLOT = ENTRIES + 1;
    localparam int SLOT_W = $clog2(NSLOT);
    localparam int KEY_W = 64;
    localparam int DATA_W = 64;

    typedef logic [SLOT_W-1:0] t_slot;

    typedef enum logic [2:0] {
        OP_ADD       = 3'd0,
        OP_LOOKUP    = 3'd1,
        OP_DEL_KEY   = 3'd2,
        OP_DEL_POS   = 3'd3,
        OP_TO_FRONT  = 3'd4,
        OP_TO_BACK   = 3'd5,
        OP_FRONT     = 3'd6,
        OP_ITERATE   = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_NONE = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_DECODE,
        CMD_SCAN_RD,
        CMD_SCAN_CMP,
        CMD_DATA_WR,
        CMD_FIFO_RD,
        CMD_ALLOC,
        CMD_LINK_RD,
        CMD_UNLINK,
        CMD_FRONT1,
        CMD_FRONT2,
        CMD_BACK1,
        CMD_BACK2,
        CMD_KD_GET,
        CMD_FAIL,
        CMD_FULL,
        CMD_RESULT
    } t_cmd_code;

    typedef struct packed {
        t_cmd_code code;
    } t_cmd;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_DATA_WR,
        S_FIFO_RD,
        S_ALLOC,
        S_LINK_RD,
        S_UNLINK,
        S_FRONT1,
        S_FRONT2,
        S_BACK1,
        S_BACK2,
        S_KD_RD,
        S_KD_GET,
        S_FAIL,
        S_FULL,
        S_RESULT
    } t_state;

    typedef struct packed {
        t_op  op;
        logic sel_ok;
        logic scan_hit;
        logic scan_last;
        logic full;
        logic out_busy;
    } t_dp_status;

    function automatic t_slot slot_inc(input t_slot x);
        t_slot r;
        if (x == SLOT_W'(ENTRIES)) begin
            r = '0;
        end else begin
            r = x + 1'b1;
        end
        return r;
    endfunction

endpackage

@@ rtl/ohte_dp.sv @@
// Datapath of the ordered hash table engine: slot memories, order links and free list.
module ohte_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ohte_pkg::t_cmd      i_cmd,
    output ohte_pkg::t_dp_status o_stat,
    input  logic [2:0]          i_req_type,
    input  logic [63:0]         i_key,
    input  logic [63:0]         i_data_in,
    input  logic [7:0]          i_position,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [1:0]          o_status,
    output logic [7:0]          o_slot,
    output logic [63:0]         o_key_out,
    output logic [63:0]         o_data_out,
    output logic [7:0]          o_next_slot,
    output logic                o_end_of_list,
    output logic [7:0]          o_entry_count
);

    logic [ohte_pkg::KEY_W-1:0]  key_mem  [ohte_pkg::NSLOT];
    logic [ohte_pkg::DATA_W-1:0] data_mem [ohte_pkg::NSLOT];
    ohte_pkg::t_slot             next_mem [ohte_pkg::NSLOT];
    ohte_pkg::t_slot             prev_mem [ohte_pkg::NSLOT];
    ohte_pkg::t_slot             fifo_mem [ohte_pkg::NSLOT];

    ohte_pkg::t_op               r_op;
    logic [ohte_pkg::KEY_W-1:0]  r_key;
    logic [ohte_pkg::DATA_W-1:0] r_data;
    logic [7:0]                  r_pos;
    ohte_pkg::t_slot             r_p;
    ohte_pkg::t_slot             r_scan;
    ohte_pkg::t_slot             r_nx;
    ohte_pkg::t_slot             r_pv;
    ohte_pkg::t_slot             r_head;
    ohte_pkg::t_slot             r_tail;
    ohte_pkg::t_slot             r_count;
    ohte_pkg::t_slot             r_fhead;
    ohte_pkg::t_slot             r_ftail;
    logic [ohte_pkg::NSLOT-1:0]  r_valid;
    logic [ohte_pkg::NSLOT-1:0]  r_fwritten;
    ohte_pkg::t_status           r_st;
    logic [ohte_pkg::KEY_W-1:0]  r_ko;
    logic [ohte_pkg::DATA_W-1:0] r_do;
    ohte_pkg::t_slot             r_nxs;
    logic                        r_eol;

    logic [ohte_pkg::KEY_W-1:0]  key_q;
    logic [ohte_pkg::DATA_W-1:0] data_q;
    ohte_pkg::t_slot             next_q;
    ohte_pkg::t_slot             prev_q;
    ohte_pkg::t_slot             fifo_q;
    logic                        r_fwq;
    ohte_pkg::t_slot             r_fidx_q;

    ohte_pkg::t_slot             key_ra;
    ohte_pkg::t_slot             p_sel;
    ohte_pkg::t_slot             alloc_p;

    logic                        key_we;
    logic                        data_we;
    ohte_pkg::t_slot             data_wa;
    logic                        next_we;
    ohte_pkg::t_slot             next_wa;
    ohte_pkg::t_slot             next_wd;
    logic                        prev_we;
    ohte_pkg::t_slot             prev_wa;
    ohte_pkg::t_slot             prev_wd;
    logic                        is_del;

    always_comb begin
        if (r_op == ohte_pkg::OP_FRONT ||
            (r_op == ohte_pkg::OP_ITERATE && r_pos == 8'd0)) begin
            p_sel = r_head;
        end else begin
            p_sel = ohte_pkg::SLOT_W'(r_pos);
        end
    end

    assign alloc_p = r_fwq ? fifo_q : ohte_pkg::slot_inc(r_fidx_q);
    assign key_ra = (i_cmd.code == ohte_pkg::CMD_SCAN_RD) ? r_scan : r_p;
    assign is_del = (r_op == ohte_pkg::OP_DEL_KEY) || (r_op == ohte_pkg::OP_DEL_POS);

    always_comb begin
        o_stat.op        = r_op;
        o_stat.sel_ok    = (p_sel != '0) && (32'(r_pos) <= ohte_pkg::ENTRIES) &&
                           r_valid[p_sel];
        o_stat.scan_hit  = r_valid[r_scan] && (key_q == r_key);
        o_stat.scan_last = (r_scan == ohte_pkg::SLOT_W'(ohte_pkg::ENTRIES));
        o_stat.full      = (32'(r_count) >= ohte_pkg::ENTRIES);
        o_stat.out_busy  = o_valid && !i_ready;
    end

    always_comb begin
        key_we  = 1'b0;
        data_we = 1'b0;
        data_wa = r_p;
        next_we = 1'b0;
        next_wa = r_p;
        next_wd = '0;
        prev_we = 1'b0;
        prev_wa = r_p;
        prev_wd = '0;
        unique case (i_cmd.code)
            ohte_pkg::CMD_ALLOC: begin
                key_we  = 1'b1;
                data_we = 1'b1;
                data_wa = alloc_p;
                next_we = 1'b1;
                next_wa = alloc_p;
                next_wd = '0;
                prev_we = 1'b1;
                prev_wa = alloc_p;
                prev_wd = r_tail;
            end
            ohte_pkg::CMD_DATA_WR: begin
                data_we = 1'b1;
            end
            ohte_pkg::CMD_UNLINK: begin
                next_we = (prev_q != '0);
                next_wa = prev_q;
                next_wd = next_q;
                prev_we = (next_q != '0);
                prev_wa = next_q;
                prev_wd = prev_q;
            end
            ohte_pkg::CMD_FRONT1: begin
                next_we = 1'b1;
                next_wd = r_head;
                prev_we = 1'b1;
                prev_wd = '0;
            end
            ohte_pkg::CMD_FRONT2: begin
                prev_we = (r_nx != '0);
                prev_wa = r_nx;
                prev_wd = r_p;
            end
            ohte_pkg::CMD_BACK1: begin
                next_we = 1'b1;
                next_wd = '0;
                prev_we = 1'b1;
                prev_wd = r_tail;
            end
            ohte_pkg::CMD_BACK2: begin
                next_we = (r_pv != '0);
                next_wa = r_pv;
                next_wd = r_p;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (key_we) begin
            key_mem[alloc_p] <= r_key;
        end
        key_q <= key_mem[key_ra];
    end

    always_ff @(posedge i_clk) begin
        if (data_we) begin
            data_mem[data_wa] <= r_data;
        end
        data_q <= data_mem[r_p];
    end

    always_ff @(posedge i_clk) begin
        if (next_we) begin
            next_mem[next_wa] <= next_wd;
        end
        next_q <= next_mem[r_p];
    end

    always_ff @(posedge i_clk) begin
        if (prev_we) begin
            prev_mem[prev_wa] <= prev_wd;
        end
        prev_q <= prev_mem[r_p];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.code == ohte_pkg::CMD_UNLINK && is_del) begin
            fifo_mem[r_ftail] <= r_p;
        end
        fifo_q   <= fifo_mem[r_fhead];
        r_fidx_q <= r_fhead;
        r_fwq    <= r_fwritten[r_fhead];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_fwritten <= '0;
            r_head     <= '0;
            r_tail     <= '0;
            r_count    <= '0;
            r_fhead    <= '0;
            r_ftail    <= ohte_pkg::SLOT_W'(ohte_pkg::ENTRIES);
            o_valid    <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                o_valid <= 1'b0;
            end
            unique case (i_cmd.code)
                ohte_pkg::CMD_LOAD: begin
                    r_op   <= ohte_pkg::t_op'(i_req_type);
                    r_key  <= i_key[ohte_pkg::KEY_W-1:0];
                    r_data <= i_data_in[ohte_pkg::DATA_W-1:0];
                    r_pos  <= i_position;
                    r_p    <= ohte_pkg::SLOT_W'(i_position);
                    r_scan <= ohte_pkg::SLOT_W'(1);
                    r_st   <= ohte_pkg::ST_OK;
                    r_ko   <= '0;
                    r_do   <= '0;
                    r_nxs  <= '0;
                    r_eol  <= 1'b0;
                end
                ohte_pkg::CMD_DECODE: begin
                    r_p <= p_sel;
                end
                ohte_pkg::CMD_SCAN_CMP: begin
                    if (o_stat.scan_hit) begin
                        r_p <= r_scan;
                    end
                    r_scan <= r_scan + 1'b1;
                end
                ohte_pkg::CMD_ALLOC: begin
                    r_valid[alloc_p] <= 1'b1;
                    r_p     <= alloc_p;
                    r_fhead <= ohte_pkg::slot_inc(r_fhead);
                    r_count <= r_count + 1'b1;
                    r_pv    <= r_tail;
                    r_tail  <= alloc_p;
                end
                ohte_pkg::CMD_UNLINK: begin
                    if (next_q == '0) begin
                        r_tail <= prev_q;
                    end
                    if (prev_q == '0) begin
                        r_head <= next_q;
                    end
                    if (is_del) begin
                        r_valid[r_p]         <= 1'b0;
                        r_fwritten[r_ftail]  <= 1'b1;
                        r_ftail              <= ohte_pkg::slot_inc(r_ftail);
                        r_count              <= r_count - 1'b1;
                    end
                end
                ohte_pkg::CMD_FRONT1: begin
                    r_nx   <= r_head;
                    r_head <= r_p;
                end
                ohte_pkg::CMD_FRONT2: begin
                    if (r_nx == '0) begin
                        r_tail <= r_p;
                    end
                end
                ohte_pkg::CMD_BACK1: begin
                    r_pv   <= r_tail;
                    r_tail <= r_p;
                end
                ohte_pkg::CMD_BACK2: begin
                    if (r_pv == '0) begin
                        r_head <= r_p;
                    end
                end
                ohte_pkg::CMD_KD_GET: begin
                    r_do <= data_q;
                    if (r_op != ohte_pkg::OP_LOOKUP) begin
                        r_ko <= key_q;
                    end
                    if (r_op == ohte_pkg::OP_ITERATE) begin
                        r_nxs <= next_q;
                        r_eol <= (next_q == '0);
                    end
                end
                ohte_pkg::CMD_FAIL: begin
                    r_st <= ohte_pkg::ST_NONE;
                end
                ohte_pkg::CMD_FULL: begin
                    r_st <= ohte_pkg::ST_FULL;
                end
                ohte_pkg::CMD_RESULT: begin
                    o_valid <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.code == ohte_pkg::CMD_RESULT) begin
            o_status      <= r_st;
            o_slot        <= (r_st == ohte_pkg::ST_OK) ? 8'(r_p) : 8'd0;
            o_key_out     <= 64'(r_ko);
            o_data_out    <= 64'(r_do);
            o_next_slot   <= 8'(r_nxs);
            o_end_of_list <= r_eol;
            o_entry_count <= 8'(r_count);
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= ohte_pkg::ENTRIES)
        else $error("Key count exceeds the table size.");
    a_count_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == 32'(r_count))
        else $error("Key count disagrees with the valid slots.");
    a_ends_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.code == ohte_pkg::CMD_NONE || i_cmd.code == ohte_pkg::CMD_LOAD) |->
        ((r_head == '0) == (r_tail == '0)))
        else $error("Front and back of the order list disagree on emptiness.");
    a_sentinel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_valid[0])
        else $error("The sentinel slot was marked as holding a key.");
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.code == ohte_pkg::CMD_RESULT |=> o_valid)
        else $error("A result was loaded without being presented.");
`endif

endmodule

@@ rtl/ohte_ctrl.sv @@
// Controller state machine of the ordered hash table engine.
module ohte_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  ohte_pkg::t_dp_status i_stat,
    output ohte_pkg::t_cmd       o_cmd
);

    ohte_pkg::t_state r_state;
    ohte_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ohte_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ohte_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = ohte_pkg::S_DECODE;
                end
            end
            ohte_pkg::S_DECODE: begin
                priority if (i_stat.op == ohte_pkg::OP_ADD ||
                             i_stat.op == ohte_pkg::OP_LOOKUP ||
                             i_stat.op == ohte_pkg::OP_DEL_KEY) begin
                    n_state = ohte_pkg::S_SCAN_RD;
                end else if (!i_stat.sel_ok) begin
                    n_state = ohte_pkg::S_FAIL;
                end else if (i_stat.op == ohte_pkg::OP_FRONT ||
                             i_stat.op == ohte_pkg::OP_ITERATE) begin
                    n_state = ohte_pkg::S_KD_RD;
                end else begin
                    n_state = ohte_pkg::S_LINK_RD;
                end
            end
            ohte_pkg::S_SCAN_RD: n_state = ohte_pkg::S_SCAN_CMP;
            ohte_pkg::S_SCAN_CMP: begin
                priority if (i_stat.scan_hit) begin
                    priority if (i_stat.op == ohte_pkg::OP_ADD) begin
                        n_state = ohte_pkg::S_DATA_WR;
                    end else if (i_stat.op == ohte_pkg::OP_LOOKUP) begin
                        n_state = ohte_pkg::S_KD_RD;
                    end else begin
                        n_state = ohte_pkg::S_LINK_RD;
                    end
                end else if (!i_stat.scan_last) begin
                    n_state = ohte_pkg::S_SCAN_RD;
                end else if (i_stat.op != ohte_pkg::OP_ADD) begin
                    n_state = ohte_pkg::S_FAIL;
                end else if (i_stat.full) begin
                    n_state = ohte_pkg::S_FULL;
                end else begin
                    n_state = ohte_pkg::S_FIFO_RD;
                end
            end
            ohte_pkg::S_DATA_WR: n_state = ohte_pkg::S_RESULT;
            ohte_pkg::S_FIFO_RD: n_state = ohte_pkg::S_ALLOC;
            ohte_pkg::S_ALLOC:   n_state = ohte_pkg::S_BACK2;
            ohte_pkg::S_LINK_RD: n_state = ohte_pkg::S_UNLINK;
            ohte_pkg::S_UNLINK: begin
                priority if (i_stat.op == ohte_pkg::OP_TO_FRONT) begin
                    n_state = ohte_pkg::S_FRONT1;
                end else if (i_stat.op == ohte_pkg::OP_TO_BACK) begin
                    n_state = ohte_pkg::S_BACK1;
                end else begin
                    n_state = ohte_pkg::S_RESULT;
                end
            end
            ohte_pkg::S_FRONT1: n_state = ohte_pkg::S_FRONT2;
            ohte_pkg::S_FRONT2: n_state = ohte_pkg::S_RESULT;
            ohte_pkg::S_BACK1:  n_state = ohte_pkg::S_BACK2;
            ohte_pkg::S_BACK2:  n_state = ohte_pkg::S_RESULT;
            ohte_pkg::S_KD_RD:  n_state = ohte_pkg::S_KD_GET;
            ohte_pkg::S_KD_GET: n_state = ohte_pkg::S_RESULT;
            ohte_pkg::S_FAIL:   n_state = ohte_pkg::S_RESULT;
            ohte_pkg::S_FULL:   n_state = ohte_pkg::S_RESULT;
            ohte_pkg::S_RESULT: begin
                if (!i_stat.out_busy) begin
                    n_state = ohte_pkg::S_IDLE;
                end
            end
            default: n_state = ohte_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_ready = (r_state == ohte_pkg::S_IDLE);
        o_cmd.code = ohte_pkg::CMD_NONE;
        unique case (r_state)
            ohte_pkg::S_IDLE: begin
                if (i_valid) begin
                    o_cmd.code = ohte_pkg::CMD_LOAD;
                end
            end
            ohte_pkg::S_DECODE:   o_cmd.code = ohte_pkg::CMD_DECODE;
            ohte_pkg::S_SCAN_RD:  o_cmd.code = ohte_pkg::CMD_SCAN_RD;
            ohte_pkg::S_SCAN_CMP: o_cmd.code = ohte_pkg::CMD_SCAN_CMP;
            ohte_pkg::S_DATA_WR:  o_cmd.code = ohte_pkg::CMD_DATA_WR;
            ohte_pkg::S_FIFO_RD:  o_cmd.code = ohte_pkg::CMD_FIFO_RD;
            ohte_pkg::S_ALLOC:    o_cmd.code = ohte_pkg::CMD_ALLOC;
            ohte_pkg::S_LINK_RD:  o_cmd.code = ohte_pkg::CMD_LINK_RD;
            ohte_pkg::S_UNLINK:   o_cmd.code = ohte_pkg::CMD_UNLINK;
            ohte_pkg::S_FRONT1:   o_cmd.code = ohte_pkg::CMD_FRONT1;
            ohte_pkg::S_FRONT2:   o_cmd.code = ohte_pkg::CMD_FRONT2;
            ohte_pkg::S_BACK1:    o_cmd.code = ohte_pkg::CMD_BACK1;
            ohte_pkg::S_BACK2:    o_cmd.code = ohte_pkg::CMD_BACK2;
            ohte_pkg::S_KD_RD:    o_cmd.code = ohte_pkg::CMD_NONE;
            ohte_pkg::S_KD_GET:   o_cmd.code = ohte_pkg::CMD_KD_GET;
            ohte_pkg::S_FAIL:     o_cmd.code = ohte_pkg::CMD_FAIL;
            ohte_pkg::S_FULL:     o_cmd.code = ohte_pkg::CMD_FULL;
            ohte_pkg::S_RESULT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.code = ohte_pkg::CMD_RESULT;
                end
            end
            default: o_cmd.code = ohte_pkg::CMD_NONE;
        endcase
    end

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_state == ohte_pkg::S_DECODE)
        else $error("An accepted request did not start decoding.");
    a_result_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.code == ohte_pkg::CMD_RESULT |=> r_state == ohte_pkg::S_IDLE)
        else $error("Controller did not return to idle after a result.");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ohte_pkg::S_IDLE |-> !o_ready)
        else $error("Request accepted while an operation was in progress.");
`endif

endmodule

@@ rtl/ordered_hash_table_engine.sv @@
// Top level of the ordered hash table engine.
// An exact-match key/data table of 255 slots with a doubly linked order list and a
// FIFO free list. One request is worked on at a time; a finished result sits in an
// output register, so the next request is taken while it waits. Key operations (add,
// lookup, delete by key) scan the key memory one slot at a time, reading a slot and then
// comparing its key, from slot 1 upward until a hit or the last slot. Position
// operations step through the dependent read-modify-writes of the link memories;
// read front and iterate read the key and data of the chosen slot. No clearing pass
// is needed after reset.
module ordered_hash_table_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_req_type,
    input  logic [63:0] i_key,
    input  logic [63:0] i_data_in,
    input  logic [7:0]  i_position,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [7:0]  o_slot,
    output logic [63:0] o_key_out,
    output logic [63:0] o_data_out,
    output logic [7:0]  o_next_slot,
    output logic        o_end_of_list,
    output logic [7:0]  o_entry_count
);

    ohte_pkg::t_cmd       cmd;
    ohte_pkg::t_dp_status stat;

    ohte_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    ohte_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_req_type    (i_req_type),
        .i_key         (i_key),
        .i_data_in     (i_data_in),
        .i_position    (i_position),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_slot        (o_slot),
        .o_key_out     (o_key_out),
        .o_data_out    (o_data_out),
        .o_next_slot   (o_next_slot),
        .o_end_of_list (o_end_of_list),
        .o_entry_count (o_entry_count)
    );

endmodule

@@ dv/tb_ordered_hash_table_engine.sv @@
// Self-checking testbench for the ordered hash table engine, driven by test tasks.
`timescale 1ns / 1ps

module tb_ordered_hash_table_engine;

    typedef struct {
        ohte_pkg::t_status status;
        bit [7:0]   slot;
        bit [63:0]  key_out;
        bit [63:0]  data_out;
        bit [7:0]   next_slot;
        bit         end_of_list;
        bit [7:0]   entry_count;
    } t_table_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [2:0]  i_req_type = '0;
    logic [63:0] i_key = '0;
    logic [63:0] i_data_in = '0;
    logic [7:0]  i_position = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_status;
    logic [7:0]  o_slot;
    logic [63:0] o_key_out;
    logic [63:0] o_data_out;
    logic [7:0]  o_next_slot;
    logic        o_end_of_list;
    logic [7:0]  o_entry_count;

    ordered_hash_table_engine DUT (.*);

    // Table shadow state.
    bit          slot_used [ohte_pkg::NSLOT];
    bit [63:0]   slot_key_q [ohte_pkg::NSLOT];
    bit [63:0]   slot_data_q [ohte_pkg::NSLOT];
    bit [7:0]    next_of [ohte_pkg::NSLOT];
    bit [7:0]    prev_of [ohte_pkg::NSLOT];
    bit [7:0]    free_ring [ohte_pkg::NSLOT];
    int          free_rd;
    int          free_wr;
    int          held_keys;

    t_table_result pending_results[$];
    int          error_count = 0;
    int          send_idle_pct = 22;
    int          recv_idle_pct = 70;
    bit          hold_request = 1'b0;
    int          hold_left = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int find_slot(bit [63:0] k);
        for (int i = 1; i <= ohte_pkg::ENTRIES; i++) begin
            if (slot_used[i] && slot_key_q[i] == k) return i;
        end
        return 0;
    endfunction

    function automatic void unlink_node(int p);
        bit [7:0] nx;
        bit [7:0] pv;
        nx = next_of[p];
        pv = prev_of[p];
        prev_of[nx] = pv;
        next_of[pv] = nx;
    endfunction

    function automatic void free_node(int p);
        unlink_node(p);
        slot_used[p] = 1'b0;
        free_ring[free_wr] = 8'(p);
        free_wr = (free_wr + 1) % ohte_pkg::NSLOT;
        held_keys--;
    endfunction

    function automatic bit position_held(bit [7:0] p);
        return p >= 1 && p <= ohte_pkg::ENTRIES && slot_used[p];
    endfunction

    function automatic t_table_result table_step(ohte_pkg::t_op op, bit [63:0] k,
                                                 bit [63:0] d, bit [7:0] pos);
        t_table_result r;
        int p;
        r = '{ohte_pkg::ST_OK, 0, 0, 0, 0, 0, 0};
        case (op)
            ohte_pkg::OP_ADD: begin
                p = find_slot(k);
                if (p == 0 && held_keys >= ohte_pkg::ENTRIES) begin
                    r.status = ohte_pkg::ST_FULL;
                end else begin
                    if (p == 0) begin
                        p = free_ring[free_rd];
                        free_rd = (free_rd + 1) % ohte_pkg::NSLOT;
                        slot_used[p] = 1'b1;
                        slot_key_q[p] = k;
                        next_of[p] = 0;
                        prev_of[p] = prev_of[0];
                        next_of[prev_of[0]] = 8'(p);
                        prev_of[0] = 8'(p);
                        held_keys++;
                    end
                    slot_data_q[p] = d;
                    r.slot = 8'(p);
                end
            end
            ohte_pkg::OP_LOOKUP: begin
                p = find_slot(k);
                if (p == 0) r.status = ohte_pkg::ST_NONE;
                else begin
                    r.slot = 8'(p);
                    r.data_out = slot_data_q[p];
                end
            end
            ohte_pkg::OP_DEL_KEY: begin
                p = find_slot(k);
                if (p == 0) r.status = ohte_pkg::ST_NONE;
                else begin
                    free_node(p);
                    r.slot = 8'(p);
                end
            end
            ohte_pkg::OP_DEL_POS: begin
                if (!position_held(pos)) r.status = ohte_pkg::ST_NONE;
                else begin
                    free_node(pos);
                    r.slot = pos;
                end
            end
            ohte_pkg::OP_TO_FRONT: begin
                if (!position_held(pos)) r.status = ohte_pkg::ST_NONE;
                else begin
                    unlink_node(pos);
                    prev_of[next_of[0]] = pos;
                    next_of[pos] = next_of[0];
                    prev_of[pos] = 0;
                    next_of[0] = pos;
                    r.slot = pos;
                end
            end
            ohte_pkg::OP_TO_BACK: begin
                if (!position_held(pos)) r.status = ohte_pkg::ST_NONE;
                else begin
                    unlink_node(pos);
                    next_of[prev_of[0]] = pos;
                    prev_of[pos] = prev_of[0];
                    next_of[pos] = 0;
                    prev_of[0] = pos;
                    r.slot = pos;
                end
            end
            ohte_pkg::OP_FRONT: begin
                p = next_of[0];
                if (p == 0 || !slot_used[p]) r.status = ohte_pkg::ST_NONE;
                else begin
                    r.slot = 8'(p);
                    r.key_out = slot_key_q[p];
                    r.data_out = slot_data_q[p];
                end
            end
            default: begin
                p = (pos == 0) ? next_of[0] : pos;
                if (p == 0 || !slot_used[p]) r.status = ohte_pkg::ST_NONE;
                else begin
                    r.slot = 8'(p);
                    r.key_out = slot_key_q[p];
                    r.data_out = slot_data_q[p];
                    r.next_slot = next_of[p];
                    r.end_of_list = (next_of[p] == 0);
                end
            end
        endcase
        r.entry_count = held_keys[7:0];
        return r;
    endfunction

    function automatic bit [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic bit [7:0] held_position();
        int start;
        int cand;
        start = $urandom_range(ohte_pkg::ENTRIES, 1);
        for (int i = 0; i < ohte_pkg::ENTRIES; i++) begin
            cand = (start + i - 1) % ohte_pkg::ENTRIES + 1;
            if (slot_used[cand]) return 8'(cand);
        end
        return 8'($urandom_range(255));
    endfunction

    function automatic bit [63:0] pick_key();
        if (held_keys > 0 && $urandom_range(99) < 60) return slot_key_q[held_position()];
        return rand_word();
    endfunction

    function automatic bit [7:0] pick_position();
        if (held_keys > 0 && $urandom_range(99) < 70) return held_position();
        return 8'($urandom_range(255));
    endfunction

    // Called at the clock edge where the previous transfer happened, or after reset.
    task automatic send_request(ohte_pkg::t_op op, bit [63:0] k, bit [63:0] d,
                                bit [7:0] pos);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 12) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req_type <= op;
        i_key <= k;
        i_data_in <= d;
        i_position <= pos;
        do @(posedge i_clk); while (!o_ready);
        pending_results.push_back(table_step(op, k, d, pos));
    endtask

    task automatic test_directed();
        send_request(ohte_pkg::OP_FRONT, 0, 0, 0);
        send_request(ohte_pkg::OP_ITERATE, 0, 0, 0);
        send_request(ohte_pkg::OP_LOOKUP, 64'h5, 0, 0);
        send_request(ohte_pkg::OP_DEL_KEY, 64'h5, 0, 0);
        send_request(ohte_pkg::OP_DEL_POS, 0, 0, 0);
        send_request(ohte_pkg::OP_TO_FRONT, 0, 0, 8'd5);
        send_request(ohte_pkg::OP_ADD, 64'h0, 64'h0, 8'hff);
        send_request(ohte_pkg::OP_ADD, '1, '1, 0);
        send_request(ohte_pkg::OP_ADD, 64'h0, 64'h1234, 0);
        send_request(ohte_pkg::OP_ADD, 64'h3, 64'h33, 0);
        send_request(ohte_pkg::OP_LOOKUP, '1, 0, 0);
        send_request(ohte_pkg::OP_ITERATE, 0, 0, 0);
        send_request(ohte_pkg::OP_ITERATE, 0, 0, 8'd2);
        send_request(ohte_pkg::OP_ITERATE, 0, 0, 8'd3);
        send_request(ohte_pkg::OP_TO_FRONT, 0, 0, 8'd3);
        send_request(ohte_pkg::OP_TO_BACK, 0, 0, 8'd2);
        send_request(ohte_pkg::OP_TO_FRONT, 0, 0, 8'd3);
        send_request(ohte_pkg::OP_FRONT, 0, 0, 0);
        send_request(ohte_pkg::OP_ITERATE, 0, 0, 8'd255);
        send_request(ohte_pkg::OP_DEL_POS, 0, 0, 8'd255);
        send_request(ohte_pkg::OP_DEL_POS, 0, 0, 8'd1);
        send_request(ohte_pkg::OP_DEL_KEY, '1, 0, 0);
        send_request(ohte_pkg::OP_TO_BACK, 0, 0, 8'd3);
        send_request(ohte_pkg::OP_ITERATE, 0, 0, 8'd3);
    endtask

    task automatic test_fill_table();
        int guard;
        guard = 0;
        while (held_keys < ohte_pkg::ENTRIES && guard < 400) begin
            send_request(ohte_pkg::OP_ADD, rand_word(), rand_word(),
                         8'($urandom_range(255)));
            guard++;
        end
        send_request(ohte_pkg::OP_ADD, rand_word(), rand_word(), 0);
        send_request(ohte_pkg::OP_ADD, slot_key_q[held_position()], rand_word(), 0);
        send_request(ohte_pkg::OP_ITERATE, 0, 0, 0);
        send_request(ohte_pkg::OP_TO_BACK, 0, 0, next_of[0]);
        send_request(ohte_pkg::OP_DEL_POS, 0, 0, held_position());
        send_request(ohte_pkg::OP_DEL_KEY, pick_key(), 0, 0);
    endtask

    task automatic test_random_mix(int count);
        ohte_pkg::t_op op;
        for (int n = 0; n < count; n++) begin
            op = ohte_pkg::t_op'($urandom_range(7));
            if (op == ohte_pkg::OP_ITERATE && $urandom_range(1) == 1) begin
                send_request(op, rand_word(), rand_word(), next_of[0]);
            end else begin
                send_request(op, pick_key(), rand_word(), pick_position());
            end
        end
    endtask

    task automatic test_backpressure();
        hold_request = 1'b1;
        for (int n = 0; n < 20; n++) begin
            send_request(ohte_pkg::OP_ITERATE, 0, 0, pick_position());
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result transfer with nothing expected");
                    error_count++;
                end else begin
                    t_table_result e;
                    e = pending_results.pop_front();
                    if (o_status !== e.status) begin
                        $error("status: expected %0d, got %0d", e.status, o_status);
                        error_count++;
                    end
                    if (o_slot !== e.slot) begin
                        $error("slot: expected %0d, got %0d", e.slot, o_slot);
                        error_count++;
                    end
                    if (o_key_out !== e.key_out) begin
                        $error("key_out: expected %h, got %h", e.key_out, o_key_out);
                        error_count++;
                    end
                    if (o_data_out !== e.data_out) begin
                        $error("data_out: expected %h, got %h", e.data_out, o_data_out);
                        error_count++;
                    end
                    if (o_next_slot !== e.next_slot) begin
                        $error("next_slot: expected %0d, got %0d", e.next_slot, o_next_slot);
                        error_count++;
                    end
                    if (o_end_of_list !== e.end_of_list) begin
                        $error("end_of_list: expected %0d, got %0d", e.end_of_list,
                               o_end_of_list);
                        error_count++;
                    end
                    if (o_entry_count !== e.entry_count) begin
                        $error("entry_count: expected %0d, got %0d", e.entry_count,
                               o_entry_count);
                        error_count++;
                    end
                end
            end
            if (hold_request) begin
                hold_left = 400;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        for (int i = 0; i < ohte_pkg::NSLOT; i++) begin
            free_ring[i] = (i < ohte_pkg::ENTRIES) ? 8'(i + 1) : 8'd0;
        end
        free_rd = 0;
        free_wr = ohte_pkg::ENTRIES;
        held_keys = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_fill_table();
        send_idle_pct = 70;
        recv_idle_pct = 22;
        test_random_mix(170);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_backpressure();
        test_random_mix(170);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #200_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
